>>> rtl/core/pkc_pkg.sv
package pkc_pkg;

  // table geometry
  localparam int TABLE_ENTRIES = 256;
  localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
  localparam int SIEVE_N       = 2048;

  // arithmetic constants
  localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
  localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;
  localparam logic [31:0] SEED_MUL    = 32'h6C07_8965;
  localparam logic [31:0] FOURTH_WORD = 32'h03DF_95B3;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_KEY_SEED       = 2'd0,
    CFG_SHUFFLE_ROUNDS = 2'd1,
    CFG_DIRECTION      = 2'd2
  } cfg_idx_t;

  // request to the shared multiplier
  typedef struct packed {
    logic        en;
    logic [31:0] a;
    logic [31:0] b;
  } mul_req_t;

  // low byte of the first 256 odd primes, starting at 3
  typedef logic [TABLE_ENTRIES-1:0][7:0] prime_rom_t;

  // sieve of odd primes, evaluated at elaboration
  function automatic prime_rom_t build_prime_rom();
    logic [SIEVE_N-1:0] comp;
    prime_rom_t         rom;
    int                 n;
    int                 c;
    int                 m;
    comp = '0;
    rom  = '0;
    n    = 0;
    for (c = 3; c < SIEVE_N; c += 2) begin
      if (!comp[c]) begin
        if (n < TABLE_ENTRIES) begin
          rom[n] = 8'(c);
          n++;
        end
        for (m = c * c; m < SIEVE_N; m += 2 * c) begin
          comp[m] = 1'b1;
        end
      end
    end
    return rom;
  endfunction

  localparam prime_rom_t PRIME_LO = build_prime_rom();

  // reflected crc-32 over one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] din);
    logic [31:0] c;
    int          i;
    c = crc ^ {24'd0, din};
    for (i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> rtl/core/pkc_ram.sv
module pkc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/pkc_mul.sv
module pkc_mul
  import pkc_pkg::*;
(
  input  logic        clk,
  input  mul_req_t    req,
  output logic [31:0] prod
);

  logic [63:0] full;
  logic [31:0] prod_r;

  assign full = req.a * req.b;

  // low word of the product, held until the next request
  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= full[31:0];
    end
  end

  assign prod = prod_r;

endmodule

>>> rtl/core/permutation_keystream_byte_cipher_core.sv
// channel | direction | handshake         | payload
// in      | input     | in_valid/in_stall | in_data_byte, in_first, in_last
// out     | output    | out_valid/out_stall | out_byte, out_crc_value, out_end_mark
// cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// a plain byte runs the keystream multiply, read and wait states, after a page key
// read when it opens a new 256-byte page; the table memory's single read port and
// the shared multiplier set this order. a first byte opens a page after a seed step
// (none for zero seed), fill, rounds (draw; reads and swap if halves differ), close.
// reset is synchronous, active low; the table memory itself is not cleared.
// an item is taken while the previous result still waits under out_stall.
module permutation_keystream_byte_cipher_core
  import pkc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [31:0] out_crc_value,
  output logic        out_end_mark,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [15:0] {
    ST_IDLE     = 16'h0001,
    ST_SEED_MUL = 16'h0002,
    ST_SEED_ADD = 16'h0004,
    ST_FILL     = 16'h0008,
    ST_DRAW     = 16'h0010,
    ST_RD_A     = 16'h0020,
    ST_RD_B     = 16'h0040,
    ST_RD_PA    = 16'h0080,
    ST_RD_PB    = 16'h0100,
    ST_WR_A     = 16'h0200,
    ST_WR_B     = 16'h0400,
    ST_PAGE_RD  = 16'h0800,
    ST_PAGE_WT  = 16'h1000,
    ST_KS_MUL   = 16'h2000,
    ST_KS_RD    = 16'h4000,
    ST_KS_WT    = 16'h8000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [31:0] key_seed_r;
  logic [15:0] rounds_cfg_r;
  logic        dir_r;

  // message state
  logic [3:0][31:0]  rng_r, rng_nxt;
  logic [15:0]       idx_r, idx_nxt;
  logic [7:0]        page_key_r, page_key_nxt;
  logic [31:0]       crc_r, crc_nxt;

  // sequencer working registers
  logic [31:0]       s_r, s_nxt;
  logic [1:0]        seed_cnt_r, seed_cnt_nxt;
  logic [ADDR_W-1:0] fill_cnt_r, fill_cnt_nxt;
  logic [15:0]       rounds_r, rounds_nxt;
  logic [15:0]       draw_r, draw_nxt;
  logic [7:0]        pa_r, pa_nxt;
  logic [7:0]        pb_r, pb_nxt;
  logic [7:0]        va_r, va_nxt;
  logic [7:0]        din_r, din_nxt;
  logic              last_r, last_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        obyte_r, obyte_nxt;
  logic [31:0]       ocrc_r, ocrc_nxt;
  logic              oend_r, oend_nxt;

  // memory and multiplier hookup
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;
  mul_req_t          mul_req;
  logic [31:0]       mul_q;

  // xorshift draw and seed step
  logic [31:0] xs_t;
  logic [31:0] draw_w;
  logic [31:0] seed_sum;
  logic [7:0]  idx_p1;
  logic [7:0]  ks_dout;
  logic [7:0]  crc_in;
  logic [31:0] crc_new;

  assign xs_t     = rng_r[0] ^ (rng_r[0] << 11);
  assign draw_w   = (rng_r[3] ^ (rng_r[3] >> 19)) ^ (xs_t ^ (xs_t >> 8));
  assign seed_sum = mul_q + 32'(seed_cnt_r) + 32'd1;
  assign idx_p1   = idx_r[7:0] + 8'd1;
  assign ks_dout  = din_r ^ ram_rdata;
  assign crc_in   = dir_r ? ks_dout : din_r;
  assign crc_new  = crc_byte(crc_r, crc_in);

  pkc_ram #(
    .WIDTH (8),
    .DEPTH (TABLE_ENTRIES)
  ) u_perm_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pkc_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (mul_q)
  );

  // configuration writes, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_seed_r   <= '0;
      rounds_cfg_r <= 16'h1000;
      dir_r        <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_KEY_SEED:       key_seed_r   <= cfg_data;
        CFG_SHUFFLE_ROUNDS: rounds_cfg_r <= cfg_data[15:0];
        CFG_DIRECTION:      dir_r        <= cfg_data[0];
        default:            ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    rng_nxt       = rng_r;
    idx_nxt       = idx_r;
    page_key_nxt  = page_key_r;
    crc_nxt       = crc_r;
    s_nxt         = s_r;
    seed_cnt_nxt  = seed_cnt_r;
    fill_cnt_nxt  = fill_cnt_r;
    rounds_nxt    = rounds_r;
    draw_nxt      = draw_r;
    pa_nxt        = pa_r;
    pb_nxt        = pb_r;
    va_nxt        = va_r;
    din_nxt       = din_r;
    last_nxt      = last_r;
    obyte_nxt     = obyte_r;
    ocrc_nxt      = ocrc_r;
    oend_nxt      = oend_r;
    out_valid_nxt = out_valid_r & out_stall;
    ram_we        = 1'b0;
    ram_waddr     = fill_cnt_r;
    ram_wdata     = fill_cnt_r;
    ram_raddr     = mul_q[ADDR_W-1:0];
    mul_req       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          din_nxt  = in_data_byte;
          last_nxt = in_last;
          if (in_first) begin
            s_nxt        = key_seed_r;
            seed_cnt_nxt = '0;
            fill_cnt_nxt = '0;
            rounds_nxt   = rounds_cfg_r;
            idx_nxt      = '0;
            crc_nxt      = ALL_ONES;
            rng_nxt      = '0;
            state_nxt    = (key_seed_r == '0) ? ST_FILL : ST_SEED_MUL;
          end else begin
            state_nxt = (idx_r[7:0] == 8'd0) ? ST_PAGE_RD : ST_KS_MUL;
          end
        end
      end
      // seed words: s = (s ^ s>>30) * mul + step
      ST_SEED_MUL: begin
        mul_req.en = 1'b1;
        mul_req.a  = s_r ^ (s_r >> 30);
        mul_req.b  = SEED_MUL;
        state_nxt  = ST_SEED_ADD;
      end
      ST_SEED_ADD: begin
        rng_nxt[seed_cnt_r] = seed_sum;
        s_nxt               = seed_sum;
        if (seed_cnt_r == 2'd2) begin
          rng_nxt[3] = FOURTH_WORD;
          state_nxt  = ST_FILL;
        end else begin
          seed_cnt_nxt = seed_cnt_r + 2'd1;
          state_nxt    = ST_SEED_MUL;
        end
      end
      // identity fill, one entry a cycle
      ST_FILL: begin
        ram_we       = 1'b1;
        fill_cnt_nxt = fill_cnt_r + ADDR_W'(1);
        if (fill_cnt_r == '1) begin
          state_nxt = ST_DRAW;
        end
      end
      // one generator draw per shuffle round
      ST_DRAW: begin
        if (rounds_r == '0) begin
          state_nxt = ST_PAGE_RD;
        end else begin
          rng_nxt    = {draw_w, rng_r[3], rng_r[2], rng_r[1]};
          draw_nxt   = draw_w[15:0];
          rounds_nxt = rounds_r - 16'd1;
          state_nxt  = (draw_w[7:0] != draw_w[15:8]) ? ST_RD_A : ST_DRAW;
        end
      end
      ST_RD_A: begin
        ram_raddr = draw_r[7:0];
        state_nxt = ST_RD_B;
      end
      ST_RD_B: begin
        ram_raddr = draw_r[15:8];
        pa_nxt    = ram_rdata;
        state_nxt = ST_RD_PA;
      end
      ST_RD_PA: begin
        ram_raddr = pa_r;
        pb_nxt    = ram_rdata;
        state_nxt = ST_RD_PB;
      end
      ST_RD_PB: begin
        ram_raddr = pb_r;
        va_nxt    = ram_rdata;
        state_nxt = ST_WR_A;
      end
      // swap entries at pa and pb
      ST_WR_A: begin
        ram_we    = 1'b1;
        ram_waddr = pa_r;
        ram_wdata = ram_rdata;
        state_nxt = ST_WR_B;
      end
      ST_WR_B: begin
        ram_we    = 1'b1;
        ram_waddr = pb_r;
        ram_wdata = va_r;
        state_nxt = ST_DRAW;
      end
      // new page key at each 256-byte boundary
      ST_PAGE_RD: begin
        ram_raddr = idx_r[15:8];
        state_nxt = ST_PAGE_WT;
      end
      ST_PAGE_WT: begin
        page_key_nxt = ram_rdata;
        state_nxt    = ST_KS_MUL;
      end
      // keystream address k * (index + 1)
      ST_KS_MUL: begin
        mul_req.en = 1'b1;
        mul_req.a  = {24'd0, PRIME_LO[page_key_r]};
        mul_req.b  = {24'd0, idx_p1};
        state_nxt  = ST_KS_RD;
      end
      ST_KS_RD: begin
        state_nxt = ST_KS_WT;
      end
      // finish the item once the output register is free
      ST_KS_WT: begin
        if (!out_valid_r || !out_stall) begin
          crc_nxt       = crc_new;
          idx_nxt       = idx_r + 16'd1;
          obyte_nxt     = ks_dout;
          ocrc_nxt      = crc_new ^ ALL_ONES;
          oend_nxt      = last_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control and message state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      rng_r       <= '0;
      idx_r       <= '0;
      page_key_r  <= '0;
      crc_r       <= ALL_ONES;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rng_r       <= rng_nxt;
      idx_r       <= idx_nxt;
      page_key_r  <= page_key_nxt;
      crc_r       <= crc_nxt;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    s_r        <= s_nxt;
    seed_cnt_r <= seed_cnt_nxt;
    fill_cnt_r <= fill_cnt_nxt;
    rounds_r   <= rounds_nxt;
    draw_r     <= draw_nxt;
    pa_r       <= pa_nxt;
    pb_r       <= pb_nxt;
    va_r       <= va_nxt;
    din_r      <= din_nxt;
    last_r     <= last_nxt;
    obyte_r    <= obyte_nxt;
    ocrc_r     <= ocrc_nxt;
    oend_r     <= oend_nxt;
  end

  assign in_stall      = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_byte      = obyte_r;
  assign out_crc_value = ocrc_r;
  assign out_end_mark  = oend_r;

endmodule

>>> rtl/core/pkc_checker.sv
module pkc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_byte,
  input logic [31:0] out_crc_value,
  input logic        out_end_mark
);

  // an accepted item makes the input stall in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accepting an item");

  // no result can appear right after an item is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared one cycle after accept");

  // returning to idle always leaves a result on the output
  a_idle_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(in_stall) |-> out_valid)
    else $error("input reopened without a result");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte)
      && $stable(out_crc_value) && $stable(out_end_mark))
    else $error("stalled result changed");

endmodule

bind permutation_keystream_byte_cipher_core pkc_checker u_pkc_checker (.*);

>>> bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pkc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 6_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 16;

  localparam logic [31:0] GF_POLY     = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
  localparam logic [31:0] SEED_MULT   = 32'h6C07_8965;
  localparam logic [31:0] SEED_WORD_3 = 32'h03DF_95B3;

  typedef struct packed {
    logic [7:0]  text;
    logic [31:0] crc;
    logic        end_mark;
  } cipher_out_t;

  // dut ports; the inputs are driven from time zero
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_first = 1'b0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic [31:0] out_crc_value;
  logic        out_end_mark;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_t    cfg_index = CFG_KEY_SEED;
  logic [31:0] cfg_data = 32'h0;

  // predictor state
  logic [31:0] key_seed;
  logic [15:0] shuffle_rounds;
  logic        encrypt_dir;
  logic [7:0]  perm [256];
  logic [7:0]  prime_lo [256];
  logic [31:0] rng_w [4];
  logic [15:0] byte_idx;
  logic [7:0]  page_sel;
  logic [31:0] crc_acc;

  cipher_out_t pending_out [$];
  int          mismatch_count = 0;
  int unsigned cycle_count = 0;
  int          in_burst = 0;
  int          out_burst = 0;
  int          stall_left = 0;

  permutation_keystream_byte_cipher_core u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_first     (in_first),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_crc_value(out_crc_value),
    .out_end_mark (out_end_mark),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // low byte of the first 256 odd primes
  function automatic void fill_prime_lows();
    int n;
    int c;
    int d;
    bit is_prime;
    n = 0;
    c = 3;
    while (n < 256) begin
      is_prime = 1'b1;
      for (d = 3; d * d <= c; d += 2) begin
        if (c % d == 0) begin
          is_prime = 1'b0;
          break;
        end
      end
      if (is_prime) begin
        prime_lo[n] = 8'(c);
        n++;
      end
      c += 2;
    end
  endfunction

  // xorshift128 step
  function automatic logic [31:0] next_draw();
    logic [31:0] t;
    t = rng_w[0] ^ (rng_w[0] << 11);
    rng_w[0] = rng_w[1];
    rng_w[1] = rng_w[2];
    rng_w[2] = rng_w[3];
    rng_w[3] = (rng_w[3] ^ (rng_w[3] >> 19)) ^ (t ^ (t >> 8));
    return rng_w[3];
  endfunction

  // reflected crc-32, one byte
  function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] v;
    int          i;
    v = c ^ {24'd0, d};
    for (i = 0; i < 8; i++) begin
      v = v[0] ? ((v >> 1) ^ GF_POLY) : (v >> 1);
    end
    return v;
  endfunction

  // reseed, rebuild and shuffle the table for a new message
  function automatic void rebuild_table();
    logic [31:0] s;
    logic [31:0] r;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  pa;
    logic [7:0]  pb;
    logic [7:0]  tmp;
    int          i;
    for (i = 0; i < 4; i++) rng_w[i] = 32'h0;
    if (key_seed != 32'h0) begin
      s = key_seed;
      s = (s ^ (s >> 30)) * SEED_MULT + 32'd1;
      rng_w[0] = s;
      s = (s ^ (s >> 30)) * SEED_MULT + 32'd2;
      rng_w[1] = s;
      s = (s ^ (s >> 30)) * SEED_MULT + 32'd3;
      rng_w[2] = s;
      rng_w[3] = SEED_WORD_3;
    end
    for (i = 0; i < 256; i++) perm[i] = 8'(i);
    for (i = 0; i < int'(shuffle_rounds); i++) begin
      r = next_draw();
      a = r[7:0];
      b = r[15:8];
      if (a != b) begin
        pa = perm[a];
        pb = perm[b];
        tmp = perm[pa];
        perm[pa] = perm[pb];
        perm[pb] = tmp;
      end
    end
    byte_idx = 16'h0;
    crc_acc = CRC_INIT;
  endfunction

  // expected result for one accepted byte
  function automatic cipher_out_t cipher_byte(input logic [7:0] din, input logic first,
                                              input logic last);
    cipher_out_t res;
    logic [7:0]  k;
    logic [7:0]  pos;
    if (first) rebuild_table();
    if (byte_idx[7:0] == 8'h00) page_sel = perm[byte_idx[15:8]];
    k = prime_lo[page_sel];
    pos = k * (byte_idx[7:0] + 8'd1);
    res.text = din ^ perm[pos];
    crc_acc = crc_step(crc_acc, encrypt_dir ? res.text : din);
    byte_idx = byte_idx + 16'd1;
    res.crc = crc_acc ^ CRC_INIT;
    res.end_mark = last;
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_count++;
    $display("mismatch %0s: expected %h got %h (cycle %0d)", what, want, got, cycle_count);
  endtask

  // idle length for either side: mostly none or short, a few long, some quiet bursts
  function automatic int idle_run(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      burst = $urandom_range(20, 100);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result checking and receiver stalls
  always @(posedge clk) begin : result_check
    cipher_out_t want;
    int          run;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_out.size() == 0) begin
        flag_mismatch("result with nothing pending", 32'h0, {24'h0, out_byte});
      end else begin
        want = pending_out.pop_front();
        if (out_byte !== want.text)
          flag_mismatch("out_byte", {24'h0, want.text}, {24'h0, out_byte});
        if (out_crc_value !== want.crc) flag_mismatch("crc_value", want.crc, out_crc_value);
        if (out_end_mark !== want.end_mark)
          flag_mismatch("end_mark", {31'h0, want.end_mark}, {31'h0, out_end_mark});
      end
    end
    if (stall_left > 0) begin
      stall_left--;
    end else begin
      run = idle_run(out_burst);
      out_stall <= (run > 0);
      stall_left = (run > 0) ? run - 1 : 0;
    end
  end

  // one item on the input channel, prediction on acceptance
  task automatic send_byte(input logic [7:0] data, input logic first, input logic last);
    int          gap;
    cipher_out_t res;
    gap = idle_run(in_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= data;
    in_first <= first;
    in_last <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
    res = cipher_byte(data, first, last);
    pending_out.insert(pending_out.size(), res);
  endtask

  // random payload; noisy sprinkles stray last marks inside
  task automatic send_message(input int len, input bit with_first, input bit with_last,
                              input bit noisy);
    int   i;
    logic l;
    for (i = 0; i < len; i++) begin
      if (i == len - 1) l = with_last;
      else l = noisy && ($urandom_range(0, 7) == 0);
      send_byte(8'($urandom_range(0, 255)), with_first && (i == 0), l);
    end
  endtask

  // wait for every pending result, then a short pause
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all three registers back to back
  task automatic load_config(input logic [31:0] seed, input logic [15:0] rounds,
                             input logic dir);
    cfg_idx_t    order [3];
    logic [31:0] vals [3];
    int          i;
    order = '{CFG_KEY_SEED, CFG_SHUFFLE_ROUNDS, CFG_DIRECTION};
    vals = '{seed, {16'h0, rounds}, {31'h0, dir}};
    for (i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= order[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (cfg_ready !== 1'b1);
    end
    cfg_valid <= 1'b0;
    key_seed = seed;
    shuffle_rounds = rounds;
    encrypt_dir = dir;
  endtask

  // reset values: zero seed leaves the table at identity; last without first continues
  task automatic test_defaults();
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h5A, 1'b0, 1'b0);
    send_byte(8'h80, 1'b0, 1'b1);
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'hC3, 1'b0, 1'b1);
    send_byte(8'h7F, 1'b1, 1'b1);
  endtask

  // register extremes: full seed with maximum rounds, zero rounds, single-bit seed, zero seed
  task automatic test_config_extremes();
    settle();
    load_config(32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h3C, 1'b0, 1'b1);
    settle();
    load_config(32'h0000_0001, 16'h0000, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b1);
    settle();
    load_config(32'h8000_0000, 16'h0001, 1'b1);
    send_byte(8'h55, 1'b1, 1'b0);
    send_byte(8'hAA, 1'b0, 1'b1);
    send_byte(8'h01, 1'b1, 1'b1);
    settle();
    load_config(32'h0000_0000, 16'h0010, 1'b1);
    send_byte(8'h96, 1'b1, 1'b0);
    send_byte(8'h69, 1'b0, 1'b1);
  endtask

  // a few page changes within one message
  task automatic test_page_crossing();
    settle();
    load_config($urandom, 16'd200, 1'($urandom_range(0, 1)));
    send_message(600, 1'b1, 1'b1, 1'b0);
  endtask

  // random phases of mostly well-formed messages with some broken framing
  task automatic test_random_traffic();
    int          sent;
    int          len;
    int          r;
    int          m;
    logic [31:0] seed;
    logic [15:0] rounds;
    sent = 0;
    while (sent < 900) begin
      settle();
      r = $urandom_range(0, 99);
      if (r < 10) seed = 32'h0;
      else if (r < 15) seed = 32'hFFFF_FFFF;
      else seed = $urandom;
      r = $urandom_range(0, 99);
      if (r < 10) rounds = 16'd0;
      else if (r < 80) rounds = 16'($urandom_range(1, 64));
      else if (r < 95) rounds = 16'($urandom_range(65, 400));
      else rounds = 16'($urandom_range(1000, 4096));
      load_config(seed, rounds, 1'($urandom_range(0, 1)));
      for (m = 0; m < $urandom_range(3, 10); m++) begin
        r = $urandom_range(0, 99);
        if (r < 70) len = $urandom_range(1, 24);
        else if (r < 92) len = $urandom_range(25, 80);
        else len = $urandom_range(240, 320);
        r = $urandom_range(0, 99);
        if (m == 0 || r < 80) send_message(len, 1'b1, 1'b1, 1'b0);
        else if (r < 88) send_message(len, 1'b1, 1'b0, 1'b0);
        else if (r < 94) send_message(len, 1'b0, 1'b1, 1'b0);
        else send_message(len, 1'($urandom_range(0, 1)), 1'b1, 1'b1);
        sent += len;
      end
    end
  endtask

  // sequence of tests
  initial begin
    fill_prime_lows();
    key_seed = 32'h0;
    shuffle_rounds = 16'd4096;
    encrypt_dir = 1'b0;
    for (int i = 0; i < 4; i++) rng_w[i] = 32'h0;
    for (int i = 0; i < 256; i++) perm[i] = 8'h00;
    byte_idx = 16'h0;
    page_sel = 8'h00;
    crc_acc = CRC_INIT;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_defaults();
    test_config_extremes();
    test_page_crossing();
    test_random_traffic();

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_out.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> permutation_keystream_byte_cipher_core.f
rtl/core/pkc_pkg.sv
rtl/core/pkc_ram.sv
rtl/core/pkc_mul.sv
rtl/core/permutation_keystream_byte_cipher_core.sv
rtl/core/pkc_checker.sv
bench/testbench.sv
